@@ rtl/core/pvt_pkg.sv @@
// ----------------------------------------------------------------------------
// pvt_pkg
// Shared types and codes for the polygon vertex table hit-test block.
// ----------------------------------------------------------------------------
package pvt_pkg;

  localparam int unsigned CoordBits   = 24;
  localparam int unsigned MaxVertices = 64;

  localparam logic [1:0] OP_APPEND  = 2'd0;
  localparam logic [1:0] OP_SPLIT   = 2'd1;
  localparam logic [1:0] OP_INSIDE  = 2'd2;
  localparam logic [1:0] OP_NEAREST = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_BAD_IDX = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam logic [23:0] NEAR_LIMIT_RESET = 24'd2560;

  typedef struct packed {
    logic [1:0]                  op;
    logic signed [CoordBits-1:0] x;
    logic signed [CoordBits-1:0] y;
    logic [7:0]                  edge_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       inside_res;
    logic       found;
    logic [5:0] nearest_index;
    logic [6:0] count_now;
  } out_item_t;

endpackage

@@ rtl/core/pvt_ram.sv @@
// ----------------------------------------------------------------------------
// pvt_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pvt_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/core/polygon_vertex_table_hit_test_top.sv @@
// ----------------------------------------------------------------------------
// polygon_vertex_table_hit_test_top
// Polygon vertex table with append, edge split, even-odd inside test and
// nearest-vertex query.
// ----------------------------------------------------------------------------
// Vertices live in one synchronous RAM (x and y side by side) with a
// registered read. Append and rejected transactions go from acceptance
// straight to the output state. Inside and nearest queries stream every
// stored vertex through the single read port and a short compute pipeline.
// A split reads both edge end points, then moves the tail of the table up
// one entry at a time through the same port (a read state, then a write
// state, per moved vertex), then writes the midpoint in the gap. The inside
// test uses two 26x26 multipliers, each followed by a register. One
// transaction is worked on at a time; the result sits in an output register,
// so the next transaction can be taken while it waits, and a new result is
// held back until the previous one has been delivered.
module polygon_vertex_table_hit_test_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [23:0]          cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  pvt_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pvt_pkg::out_item_t   out_data
);

  localparam int unsigned MAX_VERTICES = pvt_pkg::MaxVertices;
  localparam int unsigned CB  = pvt_pkg::CoordBits;
  localparam int unsigned AW  = $clog2(MAX_VERTICES);
  localparam int unsigned CW  = $clog2(MAX_VERTICES + 1);
  localparam int unsigned DW  = CB + 2;       // difference width
  localparam int unsigned PW  = 2 * DW;       // product width
  localparam int unsigned MW  = CB + 3;       // Manhattan distance width

  typedef enum logic [3:0] {
    S_IDLE, S_SPLIT_RD1, S_SPLIT_RD2, S_SPLIT_MID, S_SHIFT_RD, S_SHIFT_WR,
    S_SPLIT_INS, S_SCAN, S_DRAIN, S_OUT
  } state_t;

  state_t state;
  logic [23:0] near_limit;
  logic [CW-1:0] count;
  pvt_pkg::in_item_t item;
  logic [1:0] res_status;
  logic [CW-1:0] ptr;        // read address walker
  logic [CW-1:0] mov;        // shift destination
  logic [CB-1:0] ax, ay;     // split end point a
  logic [CB-1:0] mx, my;     // split midpoint

  // RAM
  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [2*CB-1:0] ram_wdata, ram_rdata;

  pvt_ram #(.WIDTH(2 * CB), .DEPTH(MAX_VERTICES)) u_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  logic signed [CB-1:0] rx, ry;
  assign rx = ram_rdata[2*CB-1:CB];
  assign ry = ram_rdata[CB-1:0];

  // scan pipeline: s1 = read data valid, s2 = edge/difference, s3 = products
  logic          s1_v;
  logic [AW-1:0] s1_idx;
  logic          s2_v, s2_cross, s2_dypos;
  logic signed [DW-1:0] s2_a, s2_dy, s2_dx, s2_b;
  logic          s3_v, s3_cross, s3_dypos;
  logic signed [PW-1:0] s3_p1, s3_p2;
  logic signed [CB-1:0] v0x, v0y, px, py;
  logic          have_prev;
  logic          inside_acc, found_acc;
  logic [MW-1:0] best;
  logic [AW-1:0] best_idx;
  logic [3:0]    drain;

  logic signed [CB:0] sum_x, sum_y;
  assign sum_x = $signed({ax[CB-1], ax}) + $signed({rx[CB-1], rx});
  assign sum_y = $signed({ay[CB-1], ay}) + $signed({ry[CB-1], ry});

  // Manhattan distance of the read vertex to the query point
  logic signed [CB:0] ddx, ddy;
  logic [MW-1:0]      man_dist;
  assign ddx  = $signed({rx[CB-1], rx}) - $signed({item.x[CB-1], item.x});
  assign ddy  = $signed({ry[CB-1], ry}) - $signed({item.y[CB-1], item.y});
  assign man_dist = MW'(ddx[CB] ? -ddx : ddx) + MW'(ddy[CB] ? -ddy : ddy);

  logic near_hit;
  assign near_hit = (man_dist < MW'(near_limit)) && (!found_acc || man_dist < best);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = mov[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = ptr[AW-1:0];
    case (state)
      S_IDLE: begin
        // append writes straight away on acceptance
        ram_we    = in_valid && in_data.op == pvt_pkg::OP_APPEND
                    && count < CW'(MAX_VERTICES);
        ram_waddr = AW'(count);
        ram_wdata = {in_data.x, in_data.y};
      end
      S_SHIFT_WR: begin
        ram_we = 1'b1;
      end
      S_SPLIT_INS: begin
        ram_we    = 1'b1;
        ram_wdata = {mx, my};
      end
      default: ;
    endcase
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      near_limit <= pvt_pkg::NEAR_LIMIT_RESET;
      count      <= '0;
      out_valid  <= 1'b0;
      s1_v <= 1'b0; s2_v <= 1'b0; s3_v <= 1'b0;
    end else begin
      if (cfg_we) near_limit <= cfg_wdata;
      if (state == S_OUT && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;

      s1_v    <= 1'b0;
      s2_v    <= 1'b0;
      s3_v    <= s2_v;
      s3_cross <= s2_cross;
      s3_dypos <= s2_dypos;
      s3_p1   <= s2_a * s2_dy;
      s3_p2   <= s2_dx * s2_b;

      // crossing decision on registered products
      if (s3_v && s3_cross) begin
        if ((s3_dypos && s3_p1 < s3_p2) || (!s3_dypos && s3_p1 > s3_p2))
          inside_acc <= ~inside_acc;
      end

      // stage 2: nearest test, or edge from previous (px,py) to vertex read now
      if (s1_v) begin
        if (item.op == pvt_pkg::OP_NEAREST) begin
          if (near_hit) begin
            found_acc <= 1'b1;
            best      <= man_dist;
            best_idx  <= s1_idx;
          end
        end else begin
          if (s1_idx == '0) begin
            v0x <= rx; v0y <= ry;
          end
          px <= rx; py <= ry;
          have_prev <= 1'b1;
          if (have_prev) begin
            // edge from (px,py) to (rx,ry)
            s2_v     <= 1'b1;
            s2_cross <= ((py > item.y) != (ry > item.y));
            s2_dypos <= (ry > py);
            s2_a  <= DW'(item.x) - DW'(px);
            s2_dy <= DW'(ry) - DW'(py);
            s2_dx <= DW'(rx) - DW'(px);
            s2_b  <= DW'(item.y) - DW'(py);
          end
        end
      end else if (state == S_DRAIN && drain == 4'd5 && item.op == pvt_pkg::OP_INSIDE) begin
        // closing edge: last vertex back to vertex 0
        s2_v     <= 1'b1;
        s2_cross <= ((py > item.y) != (v0y > item.y));
        s2_dypos <= (v0y > py);
        s2_a  <= DW'(item.x) - DW'(px);
        s2_dy <= DW'(v0y) - DW'(py);
        s2_dx <= DW'(v0x) - DW'(px);
        s2_b  <= DW'(item.y) - DW'(py);
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            item       <= in_data;
            ptr        <= '0;
            inside_acc <= 1'b0;
            found_acc  <= 1'b0;
            best       <= '0;
            best_idx   <= '0;
            have_prev  <= 1'b0;
            drain      <= '0;
            res_status <= pvt_pkg::ST_DONE;
            case (in_data.op)
              pvt_pkg::OP_APPEND: begin
                if (count >= CW'(MAX_VERTICES)) begin
                  res_status <= pvt_pkg::ST_FULL;
                end else begin
                  count <= count + CW'(1);
                end
                state <= S_OUT;
              end
              pvt_pkg::OP_SPLIT: begin
                if ({1'b0, in_data.edge_index} >= 9'(count)) begin
                  res_status <= pvt_pkg::ST_BAD_IDX;
                  state <= S_OUT;
                end else if (count >= CW'(MAX_VERTICES)) begin
                  res_status <= pvt_pkg::ST_FULL;
                  state <= S_OUT;
                end else begin
                  ptr   <= CW'(in_data.edge_index);
                  state <= S_SPLIT_RD1;
                end
              end
              pvt_pkg::OP_INSIDE: begin
                state <= (count < CW'(3)) ? S_OUT : S_SCAN;
              end
              default: begin
                state <= (count == '0) ? S_OUT : S_SCAN;
              end
            endcase
          end
        end
        S_SPLIT_RD1: begin
          // read of a issued; issue read of the wrap neighbor
          ptr   <= (ptr + CW'(1) >= count) ? '0 : ptr + CW'(1);
          state <= S_SPLIT_RD2;
        end
        S_SPLIT_RD2: begin
          ax <= rx; ay <= ry;
          state <= S_SPLIT_MID;
        end
        S_SPLIT_MID: begin
          mx  <= sum_x[CB:1];
          my  <= sum_y[CB:1];
          mov <= count;
          ptr <= count - CW'(1);
          state <= (count > CW'(item.edge_index) + CW'(1)) ? S_SHIFT_RD : S_SPLIT_INS;
        end
        S_SHIFT_RD: begin
          state <= S_SHIFT_WR;   // read data for ptr arrives next cycle
        end
        S_SHIFT_WR: begin
          mov <= mov - CW'(1);
          ptr <= ptr - CW'(1);
          state <= (mov - CW'(1) > CW'(item.edge_index) + CW'(1)) ? S_SHIFT_RD : S_SPLIT_INS;
        end
        S_SPLIT_INS: begin
          count <= count + CW'(1);
          state <= S_OUT;
        end
        S_SCAN: begin
          s1_v   <= 1'b1;
          s1_idx <= ptr[AW-1:0];
          ptr    <= ptr + CW'(1);
          if (ptr + CW'(1) >= count) state <= S_DRAIN;
        end
        S_DRAIN: begin
          drain <= drain + 4'd1;
          if (drain == 4'd5) begin
            // wait for closing edge to pass the product stage
          end
          if (drain == 4'd9) state <= S_OUT;
        end
        S_OUT: begin
          // hold until the previous result has left the output register
          if (!out_valid || !out_stall) begin
            out_data.status        <= res_status;
            out_data.inside_res    <= (item.op == pvt_pkg::OP_INSIDE) && inside_acc;
            out_data.found         <= (item.op == pvt_pkg::OP_NEAREST) && found_acc;
            out_data.nearest_index <= (item.op == pvt_pkg::OP_NEAREST) ? 6'(best_idx) : '0;
            out_data.count_now     <= 7'(count);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  property p_no_accept_while_busy;
    @(posedge clk) disable iff (rst) (state != S_IDLE) |-> in_stall;
  endproperty
  assert property (p_no_accept_while_busy) else $error("accept while busy");

  property p_count_bound;
    @(posedge clk) disable iff (rst) count <= CW'(MAX_VERTICES);
  endproperty
  assert property (p_count_bound) else $error("vertex count overflow");

  property p_count_step;
    @(posedge clk) disable iff (rst) (count != $past(count)) |->
      (count == $past(count) + CW'(1));
  endproperty
  assert property (p_count_step) else $error("vertex count jumped");

  property p_hold_stalled_result;
    @(posedge clk) disable iff (rst) (out_valid && out_stall) |=>
      (out_valid && $stable(out_data));
  endproperty
  assert property (p_hold_stalled_result) else $error("stalled result changed");

endmodule
